[rtl/core/uule_pkg.sv]
// uule_pkg: shared constants, types and the 6-bit character map for the uuencode line encoder.
// Used by uule_store, uule_pack and uuencode_line_encoder.
`timescale 1ns / 1ps
package uule_pkg;

	localparam int LINE_BYTES = 54;
	localparam int FILL_W     = $clog2(LINE_BYTES + 1);
	localparam int POS_W      = $clog2(LINE_BYTES + 3);
	localparam int ADDR_W     = $clog2(LINE_BYTES);
	localparam int CHAR_W     = 7;
	localparam int CNT_W      = 3;

	localparam logic [CHAR_W-1:0] CHAR_NL    = 7'h0a;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h60;
	localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
	localparam logic [CNT_W-1:0]  COUNT_ONE  = 3'd1;
	localparam logic [CNT_W-1:0]  COUNT_FOUR = 3'd4;

	localparam logic [1:0] PHASE_FIRST = 2'd0;
	localparam logic [1:0] PHASE_LAST  = 2'd3;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LEN  = 5'b00010,
		ST_RD   = 5'b00100,
		ST_GRP  = 5'b01000,
		ST_NL   = 5'b10000
	} state_t;

	typedef struct packed {
		logic shift;
		logic byte_ok;
	} pack_ctl_t;

	function automatic logic [CHAR_W-1:0] enc6(input logic [5:0] v);
		logic [CHAR_W-1:0] c;
		c = (v == 6'd0) ? CHAR_ZERO : ({1'b0, v} + 7'd32);
		return c;
	endfunction

endpackage

[rtl/core/uuencode_line_encoder.sv]
// uuencode_line_encoder: top level; byte gathering, line sequencer and output words.
// Depends on uule_pkg, uule_store and uule_pack.
`timescale 1ns / 1ps
// Bytes are gathered into a 54-entry line store; an input word that does not complete
// or flush a line leaves the encoder idle for the next word. A full store, or an end
// mark with a non-empty store, starts a line: a length word, one 4-character word per
// three bytes, a newline word. The store has one read port, so the group unit fetches
// one byte per cycle in the read state, then offers each group word and waits for its
// output handshake. in_ready is low throughout the line.
// Bytes past the stored count read as zero; the length character gives the true count.
module uuencode_line_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       has_byte,
	input  logic       end_of_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] char_a,
	output logic [6:0] char_b,
	output logic [6:0] char_c,
	output logic [6:0] char_d,
	output logic [2:0] char_count,
	output logic       line_end
);
	import uule_pkg::*;

	state_t            state_q;
	logic [FILL_W-1:0] fill_q;
	logic [POS_W-1:0]  pos_q;
	logic [1:0]        phase_q;
	logic              ok_q;

	logic              in_acc;
	logic              out_acc;
	logic              store_en;
	logic [FILL_W-1:0] fill_nx;
	logic              start;
	logic              pos_live;
	logic              rd_en;
	logic [7:0]        rd_data;
	pack_ctl_t         pctl;
	logic [CHAR_W-1:0] g_a, g_b, g_c, g_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_LEN) || (state_q == ST_GRP) || (state_q == ST_NL);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	always_comb begin
		store_en = in_acc && has_byte && (fill_q < FILL_W'(LINE_BYTES));
		fill_nx  = fill_q + FILL_W'(store_en);
		start    = (fill_nx >= FILL_W'(LINE_BYTES)) || (end_of_data && (fill_nx != '0));
		pos_live = pos_q < POS_W'(fill_q);
		rd_en    = (state_q == ST_RD) && (phase_q != PHASE_LAST) && pos_live;
		pctl.shift   = (state_q == ST_RD) && (phase_q != PHASE_FIRST);
		pctl.byte_ok = ok_q;
	end

	uule_store u_store (
		.clk     (clk),
		.wr_en   (store_en),
		.wr_addr (fill_q[ADDR_W-1:0]),
		.wr_data (data_byte),
		.rd_en   (rd_en),
		.rd_addr (pos_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	uule_pack u_pack (
		.clk     (clk),
		.ctl     (pctl),
		.byte_in (rd_data),
		.char_a  (g_a),
		.char_b  (g_b),
		.char_c  (g_c),
		.char_d  (g_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			pos_q   <= '0;
			phase_q <= PHASE_FIRST;
			ok_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						fill_q <= fill_nx;
						pos_q  <= '0;
						if (start) begin
							state_q <= ST_LEN;
						end
					end
				end
				ST_LEN: begin
					if (out_acc) begin
						state_q <= ST_RD;
						phase_q <= PHASE_FIRST;
					end
				end
				ST_RD: begin
					phase_q <= phase_q + 2'd1;
					if (phase_q != PHASE_LAST) begin
						pos_q <= pos_q + POS_W'(1);
						ok_q  <= pos_live;
					end else begin
						state_q <= ST_GRP;
					end
				end
				ST_GRP: begin
					if (out_acc) begin
						phase_q <= PHASE_FIRST;
						state_q <= pos_live ? ST_RD : ST_NL;
					end
				end
				ST_NL: begin
					if (out_acc) begin
						fill_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		char_a     = CHAR_NONE;
		char_b     = CHAR_NONE;
		char_c     = CHAR_NONE;
		char_d     = CHAR_NONE;
		char_count = COUNT_ONE;
		line_end   = 1'b0;
		unique case (state_q)
			ST_LEN: begin
				char_a = enc6(6'(fill_q));
			end
			ST_GRP: begin
				char_a     = g_a;
				char_b     = g_b;
				char_c     = g_c;
				char_d     = g_d;
				char_count = COUNT_FOUR;
			end
			ST_NL: begin
				char_a   = CHAR_NL;
				line_end = 1'b1;
			end
			default: begin
				char_a = CHAR_NONE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(LINE_BYTES))
		else $error("line store fill past line length");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a line is draining");

	a_nl_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && line_end) |=> (in_ready && fill_q == '0))
		else $error("newline word did not return to idle with empty store");

	a_group_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && char_count == COUNT_FOUR) |-> (fill_q != '0))
		else $error("group word on an empty line");
`endif

endmodule

[rtl/core/uule_store.sv]
// uule_store: line byte memory, one write and one registered read per cycle.
// Depends on uule_pkg.
`timescale 1ns / 1ps
module uule_store (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [uule_pkg::ADDR_W-1:0] wr_addr,
	input  logic [7:0]                wr_data,
	input  logic                      rd_en,
	input  logic [uule_pkg::ADDR_W-1:0] rd_addr,
	output logic [7:0]                rd_data
);
	import uule_pkg::*;

	logic [7:0] mem_q [LINE_BYTES];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/core/uule_pack.sv]
// uule_pack: shared group unit; shifts in three bytes and maps the 24 bits to four characters.
// Depends on uule_pkg.
`timescale 1ns / 1ps
module uule_pack (
	input  logic                      clk,
	input  uule_pkg::pack_ctl_t       ctl,
	input  logic [7:0]                byte_in,
	output logic [uule_pkg::CHAR_W-1:0] char_a,
	output logic [uule_pkg::CHAR_W-1:0] char_b,
	output logic [uule_pkg::CHAR_W-1:0] char_c,
	output logic [uule_pkg::CHAR_W-1:0] char_d
);
	import uule_pkg::*;

	logic [23:0] grp_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			grp_q <= {grp_q[15:0], (ctl.byte_ok ? byte_in : 8'h00)};
		end
	end

	assign char_a = enc6(grp_q[23:18]);
	assign char_b = enc6(grp_q[17:12]);
	assign char_c = enc6(grp_q[11:6]);
	assign char_d = enc6(grp_q[5:0]);

endmodule

[tb/uu_line_checker.sv]
// uu_line_checker: watches both channels of uuencode_line_encoder, predicts each output word
// from the accepted input words and compares them. Depends on uule_pkg.
`timescale 1ns / 1ps
module uu_line_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       has_byte,
	input  logic       end_of_data,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [6:0] char_a,
	input  logic [6:0] char_b,
	input  logic [6:0] char_c,
	input  logic [6:0] char_d,
	input  logic [2:0] char_count,
	input  logic       line_end,
	output int         errors,
	output int         pending,
	output int         lines_done,
	output int         words_done
);
	import uule_pkg::*;

	typedef struct packed {
		logic [6:0] a;
		logic [6:0] b;
		logic [6:0] c;
		logic [6:0] d;
		logic [2:0] cnt;
		logic       nl;
	} uu_word_t;

	logic [7:0] held_bytes [LINE_BYTES];
	int         held_count;
	uu_word_t   line_words_q [$];
	int         bad;
	int         lines;
	int         words;

	function automatic logic [6:0] uu_char(input logic [5:0] v);
		// zero goes out as a backtick
		return (v == 6'd0) ? 7'h60 : ({1'b0, v} + 7'd32);
	endfunction

	task automatic encode_line();
		int         n;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		uu_word_t   w;
		n = held_count;
		line_words_q.push_back(uu_word_t'{uu_char(6'(n)), CHAR_NONE, CHAR_NONE, CHAR_NONE,
			COUNT_ONE, 1'b0});
		for (int i = 0; i < n; i += 3) begin
			b0 = held_bytes[i];
			b1 = (i + 1 < n) ? held_bytes[i + 1] : 8'h00;
			b2 = (i + 2 < n) ? held_bytes[i + 2] : 8'h00;
			w.a   = uu_char(b0[7:2]);
			w.b   = uu_char({b0[1:0], b1[7:4]});
			w.c   = uu_char({b1[3:0], b2[7:6]});
			w.d   = uu_char(b2[5:0]);
			w.cnt = COUNT_FOUR;
			w.nl  = 1'b0;
			line_words_q.push_back(w);
		end
		line_words_q.push_back(uu_word_t'{CHAR_NL, CHAR_NONE, CHAR_NONE, CHAR_NONE,
			COUNT_ONE, 1'b1});
		held_count = 0;
		lines++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		uu_word_t got;
		uu_word_t want;
		if (!arst_n) begin
			held_count = 0;
			bad        = 0;
			lines      = 0;
			words      = 0;
			line_words_q.delete();
		end else begin
			if (in_valid && in_ready) begin
				if (has_byte && held_count < LINE_BYTES) begin
					held_bytes[held_count] = data_byte;
					held_count++;
				end
				if (held_count >= LINE_BYTES)
					encode_line();
				else if (end_of_data && held_count > 0)
					encode_line();
			end
			if (out_valid && out_ready) begin
				got = {char_a, char_b, char_c, char_d, char_count, line_end};
				if (line_words_q.size() == 0) begin
					bad++;
					if (bad <= 10)
						$display("word %0d: unexpected a=%h b=%h c=%h d=%h cnt=%0d nl=%b",
							words, got.a, got.b, got.c, got.d, got.cnt, got.nl);
				end else begin
					want = line_words_q.pop_front();
					if (got !== want) begin
						bad++;
						if (bad <= 10)
							$display({"word %0d: expected a=%h b=%h c=%h d=%h cnt=%0d nl=%b",
								" got a=%h b=%h c=%h d=%h cnt=%0d nl=%b"}, words,
								want.a, want.b, want.c, want.d, want.cnt, want.nl,
								got.a, got.b, got.c, got.d, got.cnt, got.nl);
					end
				end
				words++;
			end
		end
		errors     <= bad;
		pending    <= line_words_q.size();
		lines_done <= lines;
		words_done <= words;
	end

endmodule

[tb/tb.sv]
// tb: stimulus, clock, reset and verdict for uuencode_line_encoder.
// Depends on uule_pkg, the encoder RTL and uu_line_checker.
`timescale 1ns / 1ps
module tb;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_data;
	logic       out_valid;
	logic       out_ready;
	logic [6:0] char_a;
	logic [6:0] char_b;
	logic [6:0] char_c;
	logic [6:0] char_d;
	logic [2:0] char_count;
	logic       line_end;

	int errors;
	int pending;
	int lines_done;
	int words_done;
	int sent_bytes;
	bit quiet;
	bit held_off;

	localparam int HOLD_CYCLES = 300;

	uuencode_line_encoder u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .has_byte(has_byte), .end_of_data(end_of_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.char_a(char_a), .char_b(char_b), .char_c(char_c), .char_d(char_d),
		.char_count(char_count), .line_end(line_end)
	);

	uu_line_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .has_byte(has_byte), .end_of_data(end_of_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.char_a(char_a), .char_b(char_b), .char_c(char_c), .char_d(char_d),
		.char_count(char_count), .line_end(line_end),
		.errors(errors), .pending(pending), .lines_done(lines_done), .words_done(words_done)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("end of test: mismatches");
		$finish;
	end

	task automatic send_word(input logic [7:0] b, input logic hb, input logic eod);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		data_byte   <= b;
		has_byte    <= hb;
		end_of_data <= eod;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (hb)
			sent_bytes++;
	endtask

	// a run of bytes closed either on the last byte or by a bare end mark
	task automatic send_line(input int len, input bit close_on_byte);
		for (int i = 0; i < len; i++)
			send_word(8'($urandom), 1'b1, close_on_byte && i == len - 1);
		if (!close_on_byte)
			send_word(8'($urandom), 1'b0, 1'b1);
	endtask

	// receiver: random stalls, one long hold-off once output is flowing
	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_off && words_done >= 40) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(0, 5) == 0 ? 40 : $urandom_range(1, 6)) @(posedge clk);
		end
	end

	initial begin
		int kind;
		int len;
		arst_n       = 1'b0;
		in_valid    <= 1'b0;
		data_byte   <= 8'h00;
		has_byte    <= 1'b0;
		end_of_data <= 1'b0;
		sent_bytes   = 0;
		quiet        = 1'b0;
		held_off     = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// a word with no byte and no mark, then a bare mark, on an empty store
		send_word(8'hff, 1'b0, 1'b0);
		send_word(8'h00, 1'b0, 1'b1);
		// single zero byte: short last group
		send_word(8'h00, 1'b1, 1'b1);
		// two bytes, flushed on the second
		send_word(8'hff, 1'b1, 1'b0);
		send_word(8'h80, 1'b1, 1'b1);
		// three all-ones bytes, flushed by a bare mark, then a mark on the empty store
		send_word(8'hff, 1'b1, 1'b0);
		send_word(8'hff, 1'b1, 1'b0);
		send_word(8'hff, 1'b1, 1'b0);
		send_word(8'h5a, 1'b0, 1'b1);
		send_word(8'ha5, 1'b0, 1'b1);
		// two full groups
		send_word(8'ha5, 1'b1, 1'b0);
		send_word(8'h5a, 1'b1, 1'b0);
		send_word(8'h3c, 1'b1, 1'b0);
		send_word(8'hc3, 1'b1, 1'b0);
		send_word(8'h80, 1'b1, 1'b0);
		send_word(8'h01, 1'b1, 1'b1);
		// five bytes: last group has one pad byte
		send_word(8'h04, 1'b1, 1'b0);
		send_word(8'h10, 1'b1, 1'b0);
		send_word(8'h40, 1'b1, 1'b0);
		send_word(8'h7f, 1'b1, 1'b0);
		send_word(8'hfe, 1'b1, 1'b1);

		while (sent_bytes < 200) begin
			if (sent_bytes >= 160)
				quiet = 1'b1;
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				send_word(8'($urandom), 1'b0, 1'($urandom));
			end else if (kind == 1) begin
				len = $urandom_range(1, 8);
				repeat (len)
					send_word(8'($urandom), 1'($urandom), $urandom_range(0, 3) == 0);
			end else if (kind <= 7) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 53) : $urandom_range(1, 12);
				send_line(len, 1'($urandom));
			end else begin
				// full line with an end mark on the last byte, sometimes followed by a bare mark
				send_line(uule_pkg::LINE_BYTES, 1'b1);
				if (kind == 9)
					send_word(8'($urandom), 1'b0, 1'b1);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		$display("sent %0d data bytes; got %0d lines in %0d output words", sent_bytes,
			lines_done, words_done);
		$display("covered short groups, bare and empty end marks, full lines and a %0d-cycle stall",
			HOLD_CYCLES);
		if (errors == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[sim.f]
rtl/core/uule_pkg.sv
rtl/core/uule_store.sv
rtl/core/uule_pack.sv
rtl/core/uuencode_line_encoder.sv
tb/uu_line_checker.sv
tb/tb.sv
